@@ hw/rtl/olst_pkg.sv @@
// olst_pkg: sizes, codes, state encoding and control structs of the ordered list engine
// no dependencies; imported by olst_cell, olst_mod, ordered_list_engine and the testbench
`default_nettype none

package olst_pkg;

	// list sizing
	localparam int CAPACITY   = 16;
	localparam int WORD_WIDTH = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int POS_W      = 8;
	localparam int MOD_STEP_W = $clog2(POS_W);

	typedef logic [WORD_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [POS_W-1:0]      pos_t;

	// command codes
	localparam logic [2:0] CMD_APPEND    = 3'd0;
	localparam logic [2:0] CMD_HEAD      = 3'd1;
	localparam logic [2:0] CMD_AFTER_POS = 3'd2;
	localparam logic [2:0] CMD_AFTER_KEY = 3'd3;
	localparam logic [2:0] CMD_DEL_VALUE = 3'd4;
	localparam logic [2:0] CMD_DEL_POS   = 3'd5;

	// status codes
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_SCAN,
		S_EDIT,
		S_READ,
		S_EMPTY
	} state_t;

	typedef enum logic [1:0] {
		C_HOLD,
		C_INS,
		C_DEL,
		C_ROT
	} cell_op_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t op;
		idx_t     tgt;
		idx_t     tail;
		word_t    word;
	} cell_ctl_t;

	// position modulo unit handshake
	typedef struct packed {
		logic start;
		pos_t dividend;
		cnt_t divisor;
	} mod_req_t;

	typedef struct packed {
		logic done;
		idx_t rem;
	} mod_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/olst_if.sv @@
// olst_if: command and result channel interfaces of the ordered list engine
// no dependencies
`default_nettype none

interface olst_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [31:0] value;
	logic signed [31:0] after_key;
	logic [7:0]         position;

	modport source (output valid, cmd, value, after_key, position, input ready);
	modport sink   (input valid, cmd, value, after_key, position, output ready);
endinterface

interface olst_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [4:0]         entry_count;
	logic signed [31:0] element;
	logic               element_valid;
	logic               last;

	modport source (output valid, status, entry_count, element, element_valid, last,
		input ready);
	modport sink   (input valid, status, entry_count, element, element_valid, last,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/olst_cell.sv @@
// olst_cell: one slot of the list chain, holds a word and moves it to a neighbor
// depends on olst_pkg
`default_nettype none

module olst_cell import olst_pkg::*; (
	input  logic      clk,
	input  idx_t      idx,
	input  cell_ctl_t ctl,
	input  word_t     left,
	input  word_t     right,
	input  word_t     head,
	output word_t     word
);

	word_t word_q;
	word_t word_d;

	// local decision from own slot index against the broadcast target
	always_comb begin
		word_d = word_q;
		unique case (ctl.op)
			C_INS: begin
				if (idx > ctl.tgt) begin
					word_d = left;
				end else if (idx == ctl.tgt) begin
					word_d = ctl.word;
				end
			end
			C_DEL: begin
				if (idx >= ctl.tgt) begin
					word_d = right;
				end
			end
			C_ROT: begin
				if (idx < ctl.tail) begin
					word_d = right;
				end else if (idx == ctl.tail) begin
					word_d = head;
				end
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;

endmodule

`default_nettype wire

@@ hw/rtl/olst_mod.sv @@
// olst_mod: restoring remainder unit, position minus one modulo entry count
// depends on olst_pkg; one dividend bit per cycle
`default_nettype none

module olst_mod import olst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [MOD_STEP_W-1:0] step_q;
	pos_t                  dvd_q;
	cnt_t                  div_q;
	cnt_t                  rem_q;

	logic [CNT_W:0] trial;
	logic [CNT_W:0] diff;
	logic           fits;
	cnt_t           rem_d;

	// one restoring step
	always_comb begin
		trial = {rem_q, dvd_q[POS_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
		rem_d = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == MOD_STEP_W'(POS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[POS_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = IDX_W'(rem_q);

	// remainder stays below the divisor when it is handed out
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("remainder not below divisor");

endmodule

`default_nettype wire

@@ hw/rtl/ordered_list_engine.sv @@
// ordered_list_engine: ordered list of signed words kept in a chain of cells
// depends on olst_pkg, olst_if, olst_cell, olst_mod
//
//  channel   dir  beat contents
//  cmd_ch    in   cmd, value, after_key, position
//  res_ch    out  status, entry_count, element, element_valid, last
//
// a command passes through decode, an optional pass through the modulo unit for
// positions above one, a ring rotation over the entries for a key or value search,
// the edit when the list changes, then the readout beats (count beats, one for empty list)
// the readout rotates the chain one slot per beat, so a stalled result halts it
// reset clears the entry count and control; cell contents are not reset
// a new command is taken once the final readout beat sits in the output register
`default_nettype none

module ordered_list_engine import olst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	olst_cmd_if.sink     cmd_ch,
	olst_res_if.source   res_ch
);

	state_t state_q, state_d;
	cnt_t   count_q;
	idx_t   step_q;
	idx_t   tgt_q;
	logic   del_q;
	logic   plus1_q;
	logic   hit_q;
	logic [1:0] status_q;
	word_t  key_q;
	word_t  word_q;

	// output register
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [4:0]         out_count_q;
	logic signed [31:0] out_element_q;
	logic               out_evalid_q;
	logic               out_last_q;

	cell_ctl_t ctl;
	mod_req_t  mod_req;
	mod_rsp_t  mod_rsp;
	word_t     cell_word [CAPACITY];

	logic in_acc;
	logic load;
	logic full;
	logic empty;
	logic pos_low;
	logic match_now;
	logic scan_end;
	logic read_end;
	idx_t cnt_last;

	// decode of an incoming command
	state_t     dec_state;
	idx_t       dec_tgt;
	logic       dec_del;
	logic       dec_plus1;
	logic [1:0] dec_status;
	word_t      dec_key;

	// cell chain
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (g == 0) begin : g_first
			assign left_w = cell_word[0];
		end else begin : g_mid
			assign left_w = cell_word[g-1];
		end
		if (g == CAPACITY - 1) begin : g_end
			assign right_w = cell_word[g];
		end else begin : g_inner
			assign right_w = cell_word[g+1];
		end
		olst_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(g)),
			.ctl   (ctl),
			.left  (left_w),
			.right (right_w),
			.head  (cell_word[0]),
			.word  (cell_word[g])
		);
	end

	olst_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// shared conditions
	always_comb begin
		full      = count_q == CNT_W'(CAPACITY);
		empty     = count_q == '0;
		pos_low   = cmd_ch.position <= 8'd1;
		cnt_last  = IDX_W'(count_q - 1'b1);
		match_now = cell_word[0] == key_q;
		scan_end  = step_q == cnt_last;
		in_acc    = cmd_ch.valid && cmd_ch.ready;
		load      = ((state_q == S_READ) || (state_q == S_EMPTY)) &&
			(!out_valid_q || res_ch.ready);
		read_end  = load && (state_q == S_READ) && (step_q == cnt_last);
	end

	// command decode, order decides
	always_comb begin
		dec_state  = S_READ;
		dec_tgt    = '0;
		dec_del    = 1'b0;
		dec_plus1  = 1'b0;
		dec_status = ST_DONE;
		dec_key    = WORD_WIDTH'($unsigned(cmd_ch.value));
		priority if ((cmd_ch.cmd <= CMD_AFTER_KEY) && full) begin
			dec_status = ST_FULL;
		end else if (cmd_ch.cmd == CMD_APPEND) begin
			dec_state = S_EDIT;
			dec_tgt   = IDX_W'(count_q);
		end else if (cmd_ch.cmd == CMD_HEAD) begin
			dec_state = S_EDIT;
		end else if ((cmd_ch.cmd <= CMD_DEL_POS) && empty) begin
			dec_state  = S_EMPTY;
			dec_status = ST_EMPTY;
		end else if (cmd_ch.cmd == CMD_AFTER_POS) begin
			dec_plus1 = 1'b1;
			dec_tgt   = IDX_W'(1);
			dec_state = pos_low ? S_EDIT : S_MOD;
		end else if (cmd_ch.cmd == CMD_AFTER_KEY) begin
			dec_plus1 = 1'b1;
			dec_key   = WORD_WIDTH'($unsigned(cmd_ch.after_key));
			dec_state = S_SCAN;
		end else if (cmd_ch.cmd == CMD_DEL_VALUE) begin
			dec_del   = 1'b1;
			dec_state = S_SCAN;
		end else if (cmd_ch.cmd == CMD_DEL_POS) begin
			dec_del   = 1'b1;
			dec_state = pos_low ? S_EDIT : S_MOD;
		end else begin
			dec_state = empty ? S_EMPTY : S_READ;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = dec_state;
				end
			end
			S_MOD: begin
				if (mod_rsp.done) begin
					state_d = S_EDIT;
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = (hit_q || match_now) ? S_EDIT : S_READ;
				end
			end
			S_EDIT: begin
				state_d = (del_q && (count_q == CNT_W'(1))) ? S_EMPTY : S_READ;
			end
			S_READ: begin
				if (read_end) begin
					state_d = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_ch.ready     = state_q == S_IDLE;
		ctl.tgt          = tgt_q;
		ctl.tail         = cnt_last;
		ctl.word         = word_q;
		ctl.op           = C_HOLD;
		mod_req.start    = in_acc && (dec_state == S_MOD);
		mod_req.dividend = cmd_ch.position - 8'd1;
		mod_req.divisor  = count_q;
		unique case (state_q)
			S_SCAN: ctl.op = C_ROT;
			S_EDIT: ctl.op = del_q ? C_DEL : C_INS;
			S_READ: ctl.op = load ? C_ROT : C_HOLD;
			default: ctl.op = C_HOLD;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			step_q   <= '0;
			hit_q    <= 1'b0;
			del_q    <= 1'b0;
			plus1_q  <= 1'b0;
			status_q <= ST_DONE;
			tgt_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						status_q <= dec_status;
						tgt_q    <= dec_tgt;
						del_q    <= dec_del;
						plus1_q  <= dec_plus1;
						hit_q    <= 1'b0;
						step_q   <= '0;
					end
				end
				S_MOD: begin
					if (mod_rsp.done) begin
						tgt_q <= mod_rsp.rem + IDX_W'(plus1_q);
					end
				end
				S_SCAN: begin
					step_q <= scan_end ? '0 : step_q + 1'b1;
					if (match_now && !hit_q) begin
						hit_q <= 1'b1;
						tgt_q <= step_q + IDX_W'(plus1_q);
					end
					if (scan_end && !hit_q && !match_now) begin
						status_q <= ST_NOTFOUND;
					end
				end
				S_EDIT: begin
					count_q <= del_q ? count_q - 1'b1 : count_q + 1'b1;
					step_q  <= '0;
				end
				S_READ: begin
					if (load) begin
						step_q <= read_end ? '0 : step_q + 1'b1;
					end
				end
				default: begin
					step_q <= step_q;
				end
			endcase
		end
	end

	// command payload held for the edit
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q  <= dec_key;
			word_q <= WORD_WIDTH'($unsigned(cmd_ch.value));
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= status_q;
			if (state_q == S_EMPTY) begin
				out_count_q   <= '0;
				out_element_q <= '0;
				out_evalid_q  <= 1'b0;
				out_last_q    <= 1'b1;
			end else begin
				out_count_q   <= 5'(count_q);
				out_element_q <= 32'($signed(cell_word[0]));
				out_evalid_q  <= 1'b1;
				out_last_q    <= step_q == cnt_last;
			end
		end
	end

	assign res_ch.valid         = out_valid_q;
	assign res_ch.status        = out_status_q;
	assign res_ch.entry_count   = out_count_q;
	assign res_ch.element       = out_element_q;
	assign res_ch.element_valid = out_evalid_q;
	assign res_ch.last          = out_last_q;

	// entry count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// an accepted command always starts work
	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE))
		else $error("command accepted without leaving idle");

	// an empty-list beat is the single, final beat of its readout
	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_evalid_q) |-> (out_last_q && (out_count_q == 5'd0)))
		else $error("empty readout beat malformed");

	// modulo result only arrives while waiting for it
	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_rsp.done |-> (state_q == S_MOD))
		else $error("modulo result outside its wait state");

endmodule

`default_nettype wire

@@ verif/ordered_list_engine_tb.sv @@
// ordered_list_engine_tb: self-checking testbench for the ordered list engine
// holds a shadow list that predicts every readout beat, and drives both channels with random idling
// depends on olst_pkg, olst_if and the ordered_list_engine rtl
`default_nettype none

module ordered_list_engine_tb import olst_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam word_t W_MAX  = 32'h7FFF_FFFF;
	localparam word_t W_MIN  = 32'h8000_0000;
	localparam word_t W_ZERO = 32'h0000_0000;
	localparam word_t W_ONES = 32'hFFFF_FFFF;
	localparam int    RAND_ITEMS_PER_PHASE = 140;
	localparam int    BIAS_SPAN = 30;

	// one readout beat as seen on the result channel
	typedef struct packed {
		logic [1:0] status;
		cnt_t       entry_count;
		word_t      element;
		logic       element_valid;
		logic       last;
	} readout_beat_t;

	// shadow copy of the list plus the readout beats still owed by the block
	class list_shadow;
		word_t         shadow_list[$];
		readout_beat_t readout_due[$];
		int            errors;

		function new();
			errors = 0;
		endfunction

		function int find_first(word_t w);
			foreach (shadow_list[i])
				if (shadow_list[i] == w)
					return i;
			return -1;
		endfunction

		// head for positions of one or less, else (position - 1) modulo count
		function int slot_of(pos_t position);
			if (position <= 1 || shadow_list.size() == 0)
				return 0;
			return (int'(position) - 1) % shadow_list.size();
		endfunction

		// update the shadow list for one accepted command and queue its readout
		function void apply_command(logic [2:0] cmd, word_t value, word_t key, pos_t position);
			logic [1:0]    status;
			int            hit;
			readout_beat_t beat;
			status = ST_DONE;
			if (cmd <= CMD_AFTER_KEY && shadow_list.size() >= CAPACITY) begin
				status = ST_FULL;
			end else if (cmd == CMD_APPEND) begin
				shadow_list.push_back(value);
			end else if (cmd == CMD_HEAD) begin
				shadow_list.push_front(value);
			end else if (cmd <= CMD_DEL_POS && shadow_list.size() == 0) begin
				status = ST_EMPTY;
			end else begin
				case (cmd)
					CMD_AFTER_POS: begin
						shadow_list.insert(slot_of(position) + 1, value);
					end
					CMD_AFTER_KEY: begin
						hit = find_first(key);
						if (hit < 0)
							status = ST_NOTFOUND;
						else
							shadow_list.insert(hit + 1, value);
					end
					CMD_DEL_VALUE: begin
						hit = find_first(value);
						if (hit < 0)
							status = ST_NOTFOUND;
						else
							shadow_list.delete(hit);
					end
					CMD_DEL_POS: begin
						shadow_list.delete(slot_of(position));
					end
					default: ;
				endcase
			end

			// readout: one beat per element, a single invalid beat for an empty list
			if (shadow_list.size() == 0) begin
				beat = '{status: status, entry_count: '0, element: '0,
					element_valid: 1'b0, last: 1'b1};
				readout_due.push_back(beat);
			end else begin
				foreach (shadow_list[i]) begin
					beat.status        = status;
					beat.entry_count   = cnt_t'(shadow_list.size());
					beat.element       = shadow_list[i];
					beat.element_valid = 1'b1;
					beat.last          = (i == shadow_list.size() - 1);
					readout_due.push_back(beat);
				end
			end
		endfunction

		// compare one accepted result beat with the oldest one owed
		function void check_beat(readout_beat_t got);
			readout_beat_t want;
			if (readout_due.size() == 0) begin
				$error("result beat with nothing expected: element %0d", $signed(got.element));
				errors++;
				return;
			end
			want = readout_due.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, actual %0d", want.entry_count,
					got.entry_count);
				errors++;
			end
			if (got.element !== want.element) begin
				$error("element: expected %0d, actual %0d", $signed(want.element),
					$signed(got.element));
				errors++;
			end
			if (got.element_valid !== want.element_valid) begin
				$error("element_valid: expected %0d, actual %0d", want.element_valid,
					got.element_valid);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	olst_cmd_if cmd_ch();
	olst_res_if res_ch();

	ordered_list_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	list_shadow board = new();
	int         tx_idle_pct = 0;
	int         rx_idle_pct = 0;
	int         idle_phase  = 0;

	// clock
	always #6 clk = ~clk;

	// run limit: far above the slowest legal run at 80 percent receiver idling
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	// result side: check accepted beats, random stalls, one long hold-off in the last phase
	initial begin : result_sink
		int            hold_left;
		bit            held_once;
		readout_beat_t got;
		hold_left = 0;
		held_once = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got.status        = res_ch.status;
				got.entry_count   = res_ch.entry_count;
				got.element       = res_ch.element;
				got.element_valid = res_ch.element_valid;
				got.last          = res_ch.last;
				board.check_beat(got);
			end
			if (idle_phase == 3 && !held_once) begin
				hold_left = 200;
				held_once = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	task automatic set_idling(input int tx_pct, input int rx_pct, input int phase_id);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		idle_phase  <= phase_id;
	endtask

	// offer one command beat after a random gap and wait until it is taken
	task automatic send_command(input logic [2:0] cmd, input word_t value, input word_t key,
		input pos_t position);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.cmd       <= cmd;
		cmd_ch.value     <= value;
		cmd_ch.after_key <= key;
		cmd_ch.position  <= position;
		cmd_ch.valid     <= 1'b1;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		board.apply_command(cmd, value, key, position);
	endtask

	// hold the command side until every owed readout beat has arrived
	task automatic wait_readouts_drained();
		cmd_ch.valid <= 1'b0;
		while (board.readout_due.size() != 0)
			@(posedge clk);
	endtask

	// mix of extremes, small values that collide often, and full-range words
	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return W_MAX;
					1: return W_MIN;
					2: return W_ZERO;
					default: return W_ONES;
				endcase
			end
			1, 2, 3: return word_t'($urandom_range(0, 7)) - word_t'(4);
			default: return word_t'($urandom);
		endcase
	endfunction

	// a word already in the list most of the time, so searches hit
	function automatic word_t pick_member(input int hit_pct);
		if (board.shadow_list.size() != 0 && $urandom_range(0, 99) < hit_pct)
			return board.shadow_list[$urandom_range(0, board.shadow_list.size() - 1)];
		return pick_word();
	endfunction

	// random commands; the insert share drifts so the list swings between empty and full
	task automatic run_random(input int count);
		int         insert_bias[5];
		logic [2:0] cmd;
		word_t      value;
		word_t      key;
		pos_t       position;
		insert_bias = '{85, 35, 65, 15, 90};
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < insert_bias[(i / BIAS_SPAN) % 5])
				cmd = 3'($urandom_range(CMD_APPEND, CMD_AFTER_KEY));
			else
				cmd = 3'($urandom_range(CMD_DEL_VALUE, CMD_DEL_POS));
			value = (cmd == CMD_DEL_VALUE) ? pick_member(70) : pick_word();
			key   = pick_member(75);
			if ($urandom_range(0, 1) == 0)
				position = pos_t'($urandom_range(0, 20));
			else
				position = pos_t'($urandom_range(0, 255));
			send_command(cmd, value, key, position);
		end
	endtask

	// reset, directed commands, three random phases, drain and verdict
	initial begin : command_source
		arst_n = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.cmd       = CMD_APPEND;
		cmd_ch.value     = '0;
		cmd_ch.after_key = '0;
		cmd_ch.position  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(7, 80, 1);

		// commands that need a non-empty list
		send_command(CMD_AFTER_POS, 32'd1, W_ZERO, 8'd3);
		send_command(CMD_AFTER_KEY, 32'd2, W_ZERO, 8'd0);
		send_command(CMD_DEL_VALUE, W_ZERO, W_ZERO, 8'd0);
		send_command(CMD_DEL_POS, W_ZERO, W_ZERO, 8'd1);

		// delete of the only element empties the list
		send_command(CMD_APPEND, W_MAX, W_ZERO, 8'd0);
		send_command(CMD_DEL_POS, W_ZERO, W_ZERO, 8'd0);

		// extremes, key search hit and miss, position wrap
		send_command(CMD_HEAD, W_MIN, W_ZERO, 8'd0);
		send_command(CMD_APPEND, W_ONES, W_ZERO, 8'd0);
		send_command(CMD_AFTER_KEY, W_ZERO, W_ONES, 8'd0);
		send_command(CMD_AFTER_KEY, 32'd9, 32'd12345, 8'd0);
		send_command(CMD_DEL_VALUE, 32'd777, W_ZERO, 8'd0);
		send_command(CMD_AFTER_POS, 32'd11, W_ZERO, 8'd255);
		send_command(CMD_AFTER_POS, 32'd22, W_ZERO, 8'd0);
		send_command(CMD_DEL_POS, W_ZERO, W_ZERO, 8'd255);
		send_command(CMD_DEL_VALUE, W_MIN, W_ZERO, 8'd0);

		// fill to capacity, then every insert kind against a full list
		while (board.shadow_list.size() < CAPACITY)
			send_command(CMD_APPEND, pick_word(), W_ZERO, 8'd0);
		for (int c = CMD_APPEND; c <= CMD_AFTER_KEY; c++)
			send_command(3'(c), 32'd5, board.shadow_list[0], 8'd2);
		wait_readouts_drained();

		run_random(RAND_ITEMS_PER_PHASE);
		wait_readouts_drained();

		set_idling(80, 7, 2);
		run_random(RAND_ITEMS_PER_PHASE);
		wait_readouts_drained();

		set_idling(0, 0, 3);
		run_random(RAND_ITEMS_PER_PHASE);
		wait_readouts_drained();

		// let any stray beat show up before the verdict
		repeat (60) @(posedge clk);
		if (board.errors == 0 && board.readout_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
